FILE: design/alpm_pkg.sv
// shared types, widths and codes for the address lease pool manager
`timescale 1ns / 1ps

package alpm_pkg;

  localparam int unsigned POOL_ENTRIES_DEF = 64;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MAC_W      = 48;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned ENT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // register reset values
  localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'd3232235620;
  localparam logic [TIME_W-1:0] RESERVE_RST   = 32'd60;
  localparam logic [TIME_W-1:0] OCCUPY_RST    = 32'd3600;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OCCUPY    = 2'd2;

  // operation modes
  localparam logic [MODE_W-1:0] MODE_SWEEP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONFIRM = 2'd2;

  // entry states
  localparam logic [ENT_W-1:0] ENT_FREE     = 2'd0;
  localparam logic [ENT_W-1:0] ENT_RESERVED = 2'd1;
  localparam logic [ENT_W-1:0] ENT_OCCUPIED = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] RES_DONE         = 2'd0;
  localparam logic [STATUS_W-1:0] RES_NO_FREE      = 2'd1;
  localparam logic [STATUS_W-1:0] RES_NOT_RESERVED = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic start;
    logic sweep_step;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic sweep_done;
  } dp_sts_t;

endpackage

FILE: design/alpm_datapath.sv
// lease tables, expiry sweep, operation commit and result register
`timescale 1ns / 1ps

module alpm_datapath import alpm_pkg::*; #(
  parameter int unsigned POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [TIME_W-1:0]     now_seconds_i,
  input  logic [ADDR_W-1:0]     requested_address_i,
  input  logic [MAC_W-1:0]      client_mac_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_sts_t               sts_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [ADDR_W-1:0]     granted_address_o,
  output logic [COUNT_W-1:0]    released_count_o
);

  localparam int unsigned IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(POOL_ENTRIES + 1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(POOL_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(POOL_ENTRIES);
  localparam logic [ADDR_W-1:0] POOL_SIZE = ADDR_W'(POOL_ENTRIES);

  // configuration
  logic [ADDR_W-1:0] base_q;
  logic [TIME_W-1:0] reserve_q;
  logic [TIME_W-1:0] occupy_q;

  // latched item
  logic [MODE_W-1:0] mode_q;
  logic [TIME_W-1:0] now_q;
  logic [ADDR_W-1:0] req_q;
  logic [MAC_W-1:0]  mac_q;
  logic [IDX_W-1:0]  off_idx_q;
  logic              in_pool_q;
  logic [ADDR_W-1:0] req_off;

  // sweep
  logic [CNT_W-1:0]   cnt_q;
  logic               rd_en;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [ENT_W-1:0]   rd_st_q;
  logic [TIME_W-1:0]  rd_start_q;
  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  life;
  logic               expire;
  logic               post_free;
  logic               found_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic               tgt_res_q;
  logic [COUNT_W-1:0] rel_q;

  // commit
  logic                reserve_ok;
  logic                confirm_ok;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_granted;

  // table write port
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_st;
  logic [TIME_W-1:0] wr_start;
  logic              wr_mac_en;
  logic [MAC_W-1:0]  wr_mac;

  // tables
  logic [ENT_W-1:0]  st_mem    [POOL_ENTRIES];
  logic [TIME_W-1:0] start_mem [POOL_ENTRIES];
  logic [MAC_W-1:0]  mac_mem   [POOL_ENTRIES];

  // output register
  logic [STATUS_W-1:0] status_q;
  logic [ADDR_W-1:0]   granted_q;
  logic [COUNT_W-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= POOL_BASE_RST;
      reserve_q <= RESERVE_RST;
      occupy_q  <= OCCUPY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POOL_BASE: base_q    <= cfg_wdata_i;
        CFG_RESERVE:   reserve_q <= cfg_wdata_i;
        CFG_OCCUPY:    occupy_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign req_off = requested_address_i - base_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q    <= mode_i;
      now_q     <= now_seconds_i;
      req_q     <= requested_address_i;
      mac_q     <= client_mac_i;
      off_idx_q <= req_off[IDX_W-1:0];
      in_pool_q <= req_off < POOL_SIZE;
    end
  end

  // entry counter, shared by the clearing pass and the sweep
  assign rd_en = cmd_i.sweep_step && (cnt_q != CNT_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.clear_step || rd_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_idx_q <= cnt_q[IDX_W-1:0];
    end
  end

  // expiry check on the entry read last cycle
  assign elapsed   = now_q - rd_start_q;
  assign life      = (rd_st_q == ENT_RESERVED) ? reserve_q : occupy_q;
  assign expire    = rd_vld_q && (rd_st_q != ENT_FREE) && (elapsed > life);
  assign post_free = rd_vld_q && ((rd_st_q == ENT_FREE) || expire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      tgt_res_q <= 1'b0;
      rel_q     <= '0;
    end else if (cmd_i.start) begin
      found_q   <= 1'b0;
      tgt_res_q <= 1'b0;
      rel_q     <= '0;
    end else begin
      if (post_free && !found_q) begin
        found_q <= 1'b1;
      end
      if (expire && (rel_q != COUNT_MAX)) begin
        rel_q <= rel_q + COUNT_W'(1);
      end
      if (rd_vld_q && (rd_idx_q == off_idx_q)) begin
        tgt_res_q <= (rd_st_q == ENT_RESERVED) && !expire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (post_free && !found_q) begin
      free_idx_q <= rd_idx_q;
    end
  end

  // operation outcome
  assign reserve_ok = (mode_q == MODE_RESERVE) && found_q;
  assign confirm_ok = (mode_q == MODE_CONFIRM) && in_pool_q && tgt_res_q;

  always_comb begin
    unique case (mode_q)
      MODE_RESERVE: res_status = found_q ? RES_DONE : RES_NO_FREE;
      MODE_CONFIRM: res_status = confirm_ok ? RES_DONE : RES_NOT_RESERVED;
      default:      res_status = RES_DONE;
    endcase
  end

  always_comb begin
    priority if (reserve_ok) begin
      res_granted = base_q + ADDR_W'(free_idx_q);
    end else if (confirm_ok) begin
      res_granted = req_q;
    end else begin
      res_granted = '0;
    end
  end

  // single write port: clear, release, reserve or confirm
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = cnt_q[IDX_W-1:0];
    wr_st     = ENT_FREE;
    wr_start  = '0;
    wr_mac_en = 1'b0;
    wr_mac    = '0;
    priority if (cmd_i.clear_step) begin
      wr_en     = 1'b1;
      wr_mac_en = 1'b1;
    end else if (expire) begin
      wr_en     = 1'b1;
      wr_addr   = rd_idx_q;
      wr_mac_en = 1'b1;
    end else if (cmd_i.commit && reserve_ok) begin
      wr_en    = 1'b1;
      wr_addr  = free_idx_q;
      wr_st    = ENT_RESERVED;
      wr_start = now_q;
    end else if (cmd_i.commit && confirm_ok) begin
      wr_en     = 1'b1;
      wr_addr   = off_idx_q;
      wr_st     = ENT_OCCUPIED;
      wr_start  = now_q;
      wr_mac_en = 1'b1;
      wr_mac    = mac_q;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      st_mem[wr_addr] <= wr_st;
    end
    if (rd_en) begin
      rd_st_q <= st_mem[cnt_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[wr_addr] <= wr_start;
    end
    if (rd_en) begin
      rd_start_q <= start_mem[cnt_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_mac_en) begin
      mac_mem[wr_addr] <= wr_mac;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q  <= res_status;
      granted_q <= res_granted;
      count_q   <= rel_q;
    end
  end

  assign sts_o.clear_last = (cnt_q == CNT_LAST);
  assign sts_o.sweep_done = (cnt_q == CNT_END) && !rd_vld_q;

  assign status_o          = status_q;
  assign granted_address_o = granted_q;
  assign released_count_o  = count_q;

  a_commit_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> ((cnt_q == CNT_END) && !rd_vld_q))
    else $error("commit before the sweep has finished");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expire |-> (!cmd_i.commit && !cmd_i.clear_step))
    else $error("release write collides with another table write");

endmodule

FILE: design/alpm_ctrl.sv
// sequencing state machine for clear, sweep and commit
`timescale 1ns / 1ps

module alpm_ctrl import alpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o,
  input  dp_sts_t   sts_i
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SWEEP  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign cmd_o.clear_step = (state_q == ST_CLEAR);
  assign cmd_o.start      = accept;
  assign cmd_o.sweep_step = (state_q == ST_SWEEP);
  assign cmd_o.commit     = (state_q == ST_COMMIT) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (sts_i.clear_last) state_d = ST_IDLE;
      ST_IDLE:   if (accept) state_d = ST_SWEEP;
      ST_SWEEP:  if (sts_i.sweep_done) state_d = ST_COMMIT;
      ST_COMMIT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SWEEP))
    else $error("accepted word did not start a sweep");

  a_result_not_overwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_COMMIT) && out_valid_q && !out_ready_i) |=> (state_q == ST_COMMIT))
    else $error("commit left while the previous result was still pending");

endmodule

FILE: design/address_lease_pool_manager.sv
// top level of the address lease pool manager
// a new word is accepted only in idle, so each word's sweep and commit finish before the next
// is taken; the sweep reads one entry a cycle through the single-ported lease tables, and the
//   commit waits while the previous result is still held unaccepted
// reset: registers take their reset values, then a clearing pass frees every entry;
//   no word is accepted until it ends, configuration writes still are
`timescale 1ns / 1ps

module address_lease_pool_manager import alpm_pkg::*; #(
  parameter int unsigned POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [TIME_W-1:0]     now_seconds_i,
  input  logic [ADDR_W-1:0]     requested_address_i,
  input  logic [MAC_W-1:0]      client_mac_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [ADDR_W-1:0]     granted_address_o,
  output logic [COUNT_W-1:0]    released_count_o
);

  // each word: sweep every entry for expiry (one read a cycle, release written back
  // the cycle after), noting the lowest free entry and whether the requested entry
  // is still reserved, then one commit write for reserve or confirm
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer: clearing pass, idle, sweep, commit into the output register
  alpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // lease tables, configuration registers and result register
  alpm_datapath #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .mode_i              (mode_i),
    .now_seconds_i       (now_seconds_i),
    .requested_address_i (requested_address_i),
    .client_mac_i        (client_mac_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .status_o            (status_o),
    .granted_address_o   (granted_address_o),
    .released_count_o    (released_count_o)
  );

endmodule
